>>> hw/rtl/adc_offset_calibrate_and_scale_assert.svh
// Assertion shorthands: every check runs on the rising clock edge and is
// disabled while rst_n is low.
`ifndef ADC_OFFSET_CALIBRATE_AND_SCALE_ASSERT_SVH
`define ADC_OFFSET_CALIBRATE_AND_SCALE_ASSERT_SVH

`define AOC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define AOC_ASSERT_NEXT(label, trig, prop, msg) \
    `AOC_ASSERT(label, (trig) |=> (prop), msg)

`endif

>>> hw/rtl/aoc_pkg.sv
package aoc_pkg;

    localparam int ADC_BITS    = 12;
    localparam int OFF_W       = ADC_BITS + 8;          // Q.8 offset
    localparam int DIFF_W      = OFF_W + 1;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int RES_W       = 16;
    localparam int QUO_W       = 16;
    localparam int PROD_W      = OFF_W + 18;            // |diff| * 3.3 V Q16
    localparam int NUM_W       = PROD_W + 1 - (ADC_BITS - 2);
    localparam int DIV_STEPS   = QUO_W / 2;             // two quotient bits a step
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int BUS_PROD_W  = ADC_BITS + 25;
    localparam int BUS_SHIFT   = ADC_BITS + 8;
    localparam int UDC_W       = BUS_PROD_W + 1 - BUS_SHIFT;
    localparam int LIM_PROD_W  = RES_W + 15;
    localparam int PC_W        = 5;

    localparam logic [15:0]       W_HI         = 16'd62259;
    localparam logic [11:0]       W_LO         = 12'd3277;
    localparam logic [17:0]       VREF_Q16     = 18'd216269;
    localparam logic [24:0]       BUS_FS_Q20   = 25'd27592258;
    localparam logic [14:0]       LIM_COEF     = 15'd22702;
    localparam logic [16:0]       ROUND_Q16    = 17'd32768;
    localparam logic [QUO_W-1:0]  Q_CLAMP      = 16'd40000;
    localparam logic [RES_W-1:0]  RES_MAX      = 16'h7FFF;
    localparam logic [RES_W-1:0]  RES_MIN      = 16'h8000;
    localparam logic [CFG_W-1:0]  CALIB_RESET  = 16'd30000;
    localparam logic [CFG_W-1:0]  GAIN_RESET   = 16'd19661;
    localparam logic [CFG_W-1:0]  LIMIT_RESET  = 16'd51610;
    localparam logic [OFF_W-1:0]  OFFSET_RESET = OFF_W'(1) << (OFF_W - 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CALIB_SAMPLES  = 2'd0,
        REG_CURRENT_GAIN   = 2'd1,
        REG_BUS_VOLT_LIMIT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] calib_samples;
        logic [CFG_W-1:0] current_gain;
        logic [CFG_W-1:0] bus_volt_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE        = 2'd0,
        ST_CALIBRATING = 2'd1,
        ST_CAL_DONE    = 2'd2,
        ST_CONVERTED   = 2'd3
    } phase_status_t;

    typedef struct packed {
        logic                driver_ready;
        logic [ADC_BITS-1:0] phase_a_sample;
        logic [ADC_BITS-1:0] phase_b_sample;
        logic [ADC_BITS-1:0] bus_sample;
    } in_item_t;

    typedef struct packed {
        phase_status_t           phase_status;
        logic signed [RES_W-1:0] current_a;
        logic signed [RES_W-1:0] current_b;
        logic signed [RES_W-1:0] current_c;
        logic [RES_W-1:0]        bus_volts;
        logic [RES_W-1:0]        integrator_limit;
    } out_item_t;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_SET_IDLE,
        OP_MUL_OFF_A,
        OP_TRACK_A,
        OP_MUL_OFF_B,
        OP_TRACK_B,
        OP_FINISH_CAL,
        OP_DIFF_A,
        OP_DIFF_B,
        OP_MAG,
        OP_NUM,
        OP_DIV_STEP,
        OP_STORE_A,
        OP_STORE_B,
        OP_BUS_MUL,
        OP_BUS_CLAMP,
        OP_LIM_MUL,
        OP_LIM,
        OP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_ITEM,
        JC_NOT_READY,
        JC_CALIBRATED,
        JC_COUNT_DONE,
        JC_DIV_MORE,
        JC_OUT_BUSY
    } jcond_t;

    typedef logic [PC_W-1:0] upc_t;

    typedef struct packed {
        uop_t   op;
        jcond_t cond;
        upc_t   target;
    } ctrl_t;

    typedef struct packed {
        logic no_item;
        logic not_ready;
        logic calibrated;
        logic count_done;
        logic div_more;
        logic out_busy;
    } flags_t;

endpackage

>>> hw/rtl/aoc_if.sv
interface aoc_in_if;
    import aoc_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface aoc_out_if;
    import aoc_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/adc_offset_calibrate_and_scale.sv
// Current-sense front end: each transaction on samples (driver-ready flag plus raw
// phase A, phase B and bus ADC counts) yields exactly one transaction on results.
// While the driver is ready and not yet calibrated, the phase offsets are low-pass
// tracked for calib_samples items (status 1), the next ready item finishes
// calibration (status 2), and afterward items are converted to Q1.14 phase
// currents, clamped Q4.12 bus volts and the integrator limit (status 3); status 0
// means the driver was not ready, and all numeric fields are zero unless status is 3.
// One item is processed at a time by a microcoded sequencer: a converted item's time
// is dominated by two 8-step radix-4 divisions on the shared divider, and any item
// waits to emit while the result channel stalls. The result sits in an output
// register, so the next item is accepted while it waits. Write the configuration
// registers only while idle.
module adc_offset_calibrate_and_scale (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [aoc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [aoc_pkg::CFG_W-1:0]        cfg_data,
    aoc_in_if.sink                           samples,
    aoc_out_if.source                        results
);
    import aoc_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    ctrl_t  ctrl;
    flags_t flags;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_CALIB_SAMPLES:  cfg_next.calib_samples  = cfg_data;
                REG_CURRENT_GAIN:   cfg_next.current_gain   = cfg_data;
                REG_BUS_VOLT_LIMIT: cfg_next.bus_volt_limit = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{calib_samples:  CALIB_RESET,
                         current_gain:   GAIN_RESET,
                         bus_volt_limit: LIMIT_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign samples.ready = (ctrl.op == OP_LOAD);

    aoc_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    aoc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg       (cfg_reg),
        .in_valid  (samples.valid),
        .in_item   (samples.payload),
        .out_ready (results.ready),
        .out_valid (results.valid),
        .out_item  (results.payload),
        .flags     (flags)
    );

endmodule

>>> hw/rtl/aoc_sequencer.sv
module aoc_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  aoc_pkg::flags_t flags,
    output aoc_pkg::ctrl_t  ctrl
);
    import aoc_pkg::*;

    localparam upc_t PC_WAIT      = 5'd0;
    localparam upc_t PC_SELECT    = 5'd1;
    localparam upc_t PC_CHK_CAL   = 5'd2;
    localparam upc_t PC_CHK_CNT   = 5'd3;
    localparam upc_t PC_MUL_A     = 5'd4;
    localparam upc_t PC_TRACK_A   = 5'd5;
    localparam upc_t PC_MUL_B     = 5'd6;
    localparam upc_t PC_TRACK_B   = 5'd7;
    localparam upc_t PC_FIN       = 5'd8;
    localparam upc_t PC_DIFF_A    = 5'd9;
    localparam upc_t PC_MAG_A     = 5'd10;
    localparam upc_t PC_NUM_A     = 5'd11;
    localparam upc_t PC_DIV_A     = 5'd12;
    localparam upc_t PC_STORE_A   = 5'd13;
    localparam upc_t PC_DIFF_B    = 5'd14;
    localparam upc_t PC_MAG_B     = 5'd15;
    localparam upc_t PC_NUM_B     = 5'd16;
    localparam upc_t PC_DIV_B     = 5'd17;
    localparam upc_t PC_STORE_B   = 5'd18;
    localparam upc_t PC_BUS_MUL   = 5'd19;
    localparam upc_t PC_BUS_CLAMP = 5'd20;
    localparam upc_t PC_LIM_MUL   = 5'd21;
    localparam upc_t PC_LIM       = 5'd22;
    localparam upc_t PC_EMIT      = 5'd23;
    localparam upc_t PC_DONE      = 5'd24;

    // Microprogram: jump to target when cond holds, else fall through
    function automatic ctrl_t ucode(upc_t pc);
        ctrl_t w;
        w = '{op: OP_NOP, cond: JC_ALWAYS, target: PC_WAIT};
        case (pc)
            PC_WAIT:      w = '{op: OP_LOAD,       cond: JC_NO_ITEM,    target: PC_WAIT};
            PC_SELECT:    w = '{op: OP_SET_IDLE,   cond: JC_NOT_READY,  target: PC_EMIT};
            PC_CHK_CAL:   w = '{op: OP_NOP,        cond: JC_CALIBRATED, target: PC_DIFF_A};
            PC_CHK_CNT:   w = '{op: OP_NOP,        cond: JC_COUNT_DONE, target: PC_FIN};
            PC_MUL_A:     w = '{op: OP_MUL_OFF_A,  cond: JC_NEVER,      target: PC_WAIT};
            PC_TRACK_A:   w = '{op: OP_TRACK_A,    cond: JC_NEVER,      target: PC_WAIT};
            PC_MUL_B:     w = '{op: OP_MUL_OFF_B,  cond: JC_NEVER,      target: PC_WAIT};
            PC_TRACK_B:   w = '{op: OP_TRACK_B,    cond: JC_ALWAYS,     target: PC_EMIT};
            PC_FIN:       w = '{op: OP_FINISH_CAL, cond: JC_ALWAYS,     target: PC_EMIT};
            PC_DIFF_A:    w = '{op: OP_DIFF_A,     cond: JC_NEVER,      target: PC_WAIT};
            PC_MAG_A:     w = '{op: OP_MAG,        cond: JC_NEVER,      target: PC_WAIT};
            PC_NUM_A:     w = '{op: OP_NUM,        cond: JC_NEVER,      target: PC_WAIT};
            PC_DIV_A:     w = '{op: OP_DIV_STEP,   cond: JC_DIV_MORE,   target: PC_DIV_A};
            PC_STORE_A:   w = '{op: OP_STORE_A,    cond: JC_NEVER,      target: PC_WAIT};
            PC_DIFF_B:    w = '{op: OP_DIFF_B,     cond: JC_NEVER,      target: PC_WAIT};
            PC_MAG_B:     w = '{op: OP_MAG,        cond: JC_NEVER,      target: PC_WAIT};
            PC_NUM_B:     w = '{op: OP_NUM,        cond: JC_NEVER,      target: PC_WAIT};
            PC_DIV_B:     w = '{op: OP_DIV_STEP,   cond: JC_DIV_MORE,   target: PC_DIV_B};
            PC_STORE_B:   w = '{op: OP_STORE_B,    cond: JC_NEVER,      target: PC_WAIT};
            PC_BUS_MUL:   w = '{op: OP_BUS_MUL,    cond: JC_NEVER,      target: PC_WAIT};
            PC_BUS_CLAMP: w = '{op: OP_BUS_CLAMP,  cond: JC_NEVER,      target: PC_WAIT};
            PC_LIM_MUL:   w = '{op: OP_LIM_MUL,    cond: JC_NEVER,      target: PC_WAIT};
            PC_LIM:       w = '{op: OP_LIM,        cond: JC_NEVER,      target: PC_WAIT};
            PC_EMIT:      w = '{op: OP_EMIT,       cond: JC_OUT_BUSY,   target: PC_EMIT};
            PC_DONE:      w = '{op: OP_NOP,        cond: JC_ALWAYS,     target: PC_WAIT};
            default:      ;
        endcase
        return w;
    endfunction

    upc_t pc_reg;
    upc_t pc_next;
    logic taken;

    assign ctrl = ucode(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            JC_NEVER:      taken = 1'b0;
            JC_ALWAYS:     taken = 1'b1;
            JC_NO_ITEM:    taken = flags.no_item;
            JC_NOT_READY:  taken = flags.not_ready;
            JC_CALIBRATED: taken = flags.calibrated;
            JC_COUNT_DONE: taken = flags.count_done;
            JC_DIV_MORE:   taken = flags.div_more;
            JC_OUT_BUSY:   taken = flags.out_busy;
            default:       taken = 1'b0;
        endcase
        pc_next = taken ? ctrl.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> hw/rtl/aoc_datapath.sv
`include "adc_offset_calibrate_and_scale_assert.svh"

module aoc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  aoc_pkg::ctrl_t     ctrl,
    input  aoc_pkg::cfg_t      cfg,
    input  logic               in_valid,
    input  aoc_pkg::in_item_t  in_item,
    input  logic               out_ready,
    output logic               out_valid,
    output aoc_pkg::out_item_t out_item,
    output aoc_pkg::flags_t    flags
);
    import aoc_pkg::*;

    // Q1.14 result from clamped quotient and sign of the offset difference
    function automatic logic [RES_W-1:0] to_amps(logic [QUO_W-1:0] q, logic sat, logic neg);
        logic [QUO_W-1:0] r;
        logic [QUO_W:0]   neg_r;
        logic [RES_W-1:0] res;
        r     = (sat || (q > Q_CLAMP)) ? Q_CLAMP : q;
        neg_r = '0 - {1'b0, r};
        if (neg)
        begin
            res = (r > RES_MAX) ? RES_MAX : r;
        end
        else
        begin
            res = (r >= RES_MIN) ? RES_MIN : neg_r[RES_W-1:0];
        end
        return res;
    endfunction

    // state
    in_item_t                item_reg, item_next;
    logic [OFF_W-1:0]        offset_a_reg, offset_a_next;
    logic [OFF_W-1:0]        offset_b_reg, offset_b_next;
    logic [CFG_W-1:0]        sample_count_reg, sample_count_next;
    logic                    calibrated_reg, calibrated_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic                    out_valid_reg, out_valid_next;

    // working registers
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic [CFG_W-1:0]        rem_reg, rem_next;
    logic                    sat_reg, sat_next;
    phase_status_t           status_reg, status_next;
    logic [RES_W-1:0]        ia_reg, ia_next;
    logic [RES_W-1:0]        ib_reg, ib_next;
    logic [RES_W-1:0]        ic_reg, ic_next;
    logic [RES_W-1:0]        udc_reg, udc_next;
    logic [RES_W-1:0]        lim_reg, lim_next;
    out_item_t               out_item_reg, out_item_next;

    // combinational helpers
    logic [CFG_W-1:0]        gain_eff;
    logic                    emit_fire;
    logic [OFF_W-1:0]        mul_off;
    logic [ADC_BITS-1:0]     trk_sample;
    logic [PROD_W:0]         trk_lo_op, trk_smp, trk_acc;
    logic [PROD_W-1:0]       mul_a, mul_b;
    logic signed [DIFF_W-1:0] diff_neg;
    logic [PROD_W:0]         gain_wide, num_sum, num_shift;
    logic [NUM_W-1:0]        num;
    logic [CFG_W:0]          dv_t1, dv_t2;
    logic [CFG_W:0]          dv_r1, dv_r2;
    logic                    dv_ge1, dv_ge2;
    logic signed [RES_W:0]   ab_sum;
    logic signed [RES_W+1:0] c_wide;
    logic [BUS_PROD_W:0]     bus_sum;
    logic [UDC_W-1:0]        bus_v;
    logic [LIM_PROD_W:0]     lim_sum;

    assign gain_eff  = (cfg.current_gain == '0) ? CFG_W'(1) : cfg.current_gain;
    assign emit_fire = (ctrl.op == OP_EMIT) && !(out_valid_reg && !out_ready);

    assign flags.no_item    = !in_valid;
    assign flags.not_ready  = !item_reg.driver_ready;
    assign flags.calibrated = calibrated_reg;
    assign flags.count_done = sample_count_reg >= cfg.calib_samples;
    assign flags.div_more   = div_cnt_reg != '0;
    assign flags.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        // shared arithmetic
        mul_off    = (ctrl.op == OP_MUL_OFF_B) ? offset_b_reg : offset_a_reg;
        trk_sample = (ctrl.op == OP_TRACK_B) ? item_reg.phase_b_sample
                                             : item_reg.phase_a_sample;
        trk_lo_op  = (PROD_W+1)'(W_LO);
        trk_smp    = (PROD_W+1)'({trk_sample, 8'd0});
        trk_acc    = {1'b0, prod_reg} + trk_lo_op * trk_smp + (PROD_W+1)'(ROUND_Q16);

        diff_neg   = -diff_reg;

        gain_wide  = (PROD_W+1)'(gain_eff);
        num_sum    = {1'b0, prod_reg} + (gain_wide << (ADC_BITS - 3));
        num_shift  = num_sum >> (ADC_BITS - 2);
        num        = num_shift[NUM_W-1:0];

        // radix-4 restoring division step, two dependent compare-subtracts
        dv_t1  = {rem_reg, quo_reg[QUO_W-1]};
        dv_ge1 = dv_t1 >= {1'b0, gain_eff};
        dv_r1  = dv_ge1 ? dv_t1 - {1'b0, gain_eff} : dv_t1;
        dv_t2  = {dv_r1[CFG_W-1:0], quo_reg[QUO_W-2]};
        dv_ge2 = dv_t2 >= {1'b0, gain_eff};
        dv_r2  = dv_ge2 ? dv_t2 - {1'b0, gain_eff} : dv_t2;

        ab_sum = $signed({ia_reg[RES_W-1], ia_reg}) + $signed({ib_reg[RES_W-1], ib_reg});
        c_wide = -$signed({ab_sum[RES_W], ab_sum});

        bus_sum = {1'b0, prod_reg[BUS_PROD_W-1:0]}
                + ((BUS_PROD_W+1)'(1) << (ADC_BITS + 7));
        bus_v   = bus_sum[BUS_PROD_W:BUS_SHIFT];
        lim_sum = {1'b0, prod_reg[LIM_PROD_W-1:0]} + (LIM_PROD_W+1)'(ROUND_Q16);

        mul_a = '0;
        mul_b = '0;

        item_next         = item_reg;
        offset_a_next     = offset_a_reg;
        offset_b_next     = offset_b_reg;
        sample_count_next = sample_count_reg;
        calibrated_next   = calibrated_reg;
        div_cnt_next      = div_cnt_reg;
        prod_next         = prod_reg;
        diff_next         = diff_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        sat_next          = sat_reg;
        status_next       = status_reg;
        ia_next           = ia_reg;
        ib_next           = ib_reg;
        ic_next           = ic_reg;
        udc_next          = udc_reg;
        lim_next          = lim_reg;

        unique case (ctrl.op) inside
            OP_NOP, OP_EMIT: ;
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    item_next = in_item;
                end
            end
            OP_SET_IDLE:
            begin
                status_next = ST_IDLE;
                ia_next     = '0;
                ib_next     = '0;
                ic_next     = '0;
                udc_next    = '0;
                lim_next    = '0;
            end
            OP_MUL_OFF_A, OP_MUL_OFF_B:
            begin
                mul_a     = PROD_W'(W_HI);
                mul_b     = PROD_W'(mul_off);
                prod_next = mul_a * mul_b;
            end
            OP_TRACK_A:
            begin
                offset_a_next = trk_acc[16 +: OFF_W];
            end
            OP_TRACK_B:
            begin
                offset_b_next     = trk_acc[16 +: OFF_W];
                sample_count_next = sample_count_reg + CFG_W'(1);
                status_next       = ST_CALIBRATING;
            end
            OP_FINISH_CAL:
            begin
                calibrated_next   = 1'b1;
                sample_count_next = '0;
                status_next       = ST_CAL_DONE;
            end
            OP_DIFF_A:
            begin
                diff_next   = $signed({1'b0, item_reg.phase_a_sample, 8'd0})
                            - $signed({1'b0, offset_a_reg});
                status_next = ST_CONVERTED;
            end
            OP_DIFF_B:
            begin
                diff_next = $signed({1'b0, item_reg.phase_b_sample, 8'd0})
                          - $signed({1'b0, offset_b_reg});
            end
            OP_MAG:
            begin
                mul_a     = diff_reg[DIFF_W-1] ? PROD_W'(diff_neg[OFF_W-1:0])
                                               : PROD_W'(diff_reg[OFF_W-1:0]);
                mul_b     = PROD_W'(VREF_Q16);
                prod_next = mul_a * mul_b;
            end
            OP_NUM:
            begin
                // quotient of 2^16 or more is clamped anyway
                quo_next     = num[QUO_W-1:0];
                rem_next     = CFG_W'(num[NUM_W-1:QUO_W]);
                sat_next     = CFG_W'(num[NUM_W-1:QUO_W]) >= gain_eff;
                div_cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
            end
            OP_DIV_STEP:
            begin
                quo_next     = {quo_reg[QUO_W-3:0], dv_ge1, dv_ge2};
                rem_next     = dv_r2[CFG_W-1:0];
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
            end
            OP_STORE_A:
            begin
                ia_next = to_amps(quo_reg, sat_reg, diff_reg[DIFF_W-1]);
            end
            OP_STORE_B:
            begin
                ib_next = to_amps(quo_reg, sat_reg, diff_reg[DIFF_W-1]);
            end
            OP_BUS_MUL:
            begin
                mul_a     = PROD_W'(item_reg.bus_sample);
                mul_b     = PROD_W'(BUS_FS_Q20);
                prod_next = mul_a * mul_b;
            end
            OP_BUS_CLAMP:
            begin
                udc_next = (bus_v > UDC_W'(cfg.bus_volt_limit)) ? cfg.bus_volt_limit
                                                                : bus_v[RES_W-1:0];
                if (c_wide[RES_W+1:RES_W-1] == 3'b000 || c_wide[RES_W+1:RES_W-1] == 3'b111)
                begin
                    ic_next = c_wide[RES_W-1:0];
                end
                else
                begin
                    ic_next = c_wide[RES_W+1] ? RES_MIN : RES_MAX;
                end
            end
            OP_LIM_MUL:
            begin
                mul_a     = PROD_W'(udc_reg);
                mul_b     = PROD_W'(LIM_COEF);
                prod_next = mul_a * mul_b;
            end
            OP_LIM:
            begin
                lim_next = lim_sum[LIM_PROD_W:16];
            end
            default: ;
        endcase

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end

        out_item_next = out_item_reg;
        if (emit_fire)
        begin
            out_item_next = '{phase_status:     status_reg,
                              current_a:        ia_reg,
                              current_b:        ib_reg,
                              current_c:        ic_reg,
                              bus_volts:        udc_reg,
                              integrator_limit: lim_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_a_reg     <= OFFSET_RESET;
            offset_b_reg     <= OFFSET_RESET;
            sample_count_reg <= '0;
            calibrated_reg   <= 1'b0;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            offset_a_reg     <= offset_a_next;
            offset_b_reg     <= offset_b_next;
            sample_count_reg <= sample_count_next;
            calibrated_reg   <= calibrated_next;
            div_cnt_reg      <= div_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        diff_reg     <= diff_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        sat_reg      <= sat_next;
        status_reg   <= status_next;
        ia_reg       <= ia_next;
        ib_reg       <= ib_next;
        ic_reg       <= ic_next;
        udc_reg      <= udc_next;
        lim_reg      <= lim_next;
        out_item_reg <= out_item_next;
    end

    `AOC_ASSERT(a_cal_sticky, !$fell(calibrated_reg), "calibrated flag dropped")
    `AOC_ASSERT(a_count_idle, !calibrated_reg || sample_count_reg == '0,
                "count moved after calibration")
    `AOC_ASSERT(a_offset_src, $stable(offset_a_reg) || $past(ctrl.op) == OP_TRACK_A,
                "offset A changed outside tracking")
    `AOC_ASSERT(a_zero_unconv, !out_valid_reg || out_item_reg.phase_status == ST_CONVERTED
                || (out_item_reg.current_a == '0 && out_item_reg.current_c == '0
                && out_item_reg.bus_volts == '0), "unconverted result carries data")

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import aoc_pkg::*;

    localparam int     CLK_HALF     = 2;
    localparam int     RESET_CYCLES = 7;
    localparam int     ADC_MAX      = (1 << ADC_BITS) - 1;
    localparam int     HOLD_CYCLES  = 300;   // long result stall, fills the block
    localparam int     STALL_LIMIT  = 3000;  // cycles without any transaction
    localparam int     IDLE_SETTLE  = 6;     // block finishes its last item
    localparam int     TAIL_CYCLES  = 50;

    // Filter and scaling constants, Q0.16 / Q16 / Q20
    localparam longint FILT_KEEP   = 62259;
    localparam longint FILT_NEW    = 3277;
    localparam longint VREF_AMPS   = 216269;
    localparam longint AMPS_CLAMP  = 40000;
    localparam longint BUS_SCALE   = 27592258;
    localparam longint LIM_SCALE   = 22702;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wen;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    aoc_in_if  samples_ch ();
    aoc_out_if results_ch ();

    adc_offset_calibrate_and_scale DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_ch),
        .results   (results_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    // Shadow of the block's registers and calibration state
    logic [CFG_W-1:0] calib_len  = 16'd30000;
    logic [CFG_W-1:0] gain_reg   = 16'd19661;
    logic [CFG_W-1:0] volt_limit = 16'd51610;
    logic [OFF_W-1:0] offset_a   = OFF_W'(1) << (ADC_BITS + 7);
    logic [OFF_W-1:0] offset_b   = OFF_W'(1) << (ADC_BITS + 7);
    logic [15:0]      cal_count  = '0;
    bit               is_calibrated = 1'b0;

    out_item_t expected_results[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        reg_writes = 0;
    int        status_seen [4] = '{default: 0};
    int        send_calm = 0;
    int        sink_calm = 0;
    bit        hold_results_req = 1'b0;

    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic signed [RES_W-1:0] clip16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return RES_W'(v);
    endfunction

    function automatic logic [OFF_W-1:0] filter_offset(logic [OFF_W-1:0] prev,
                                                       logic [ADC_BITS-1:0] s);
        longint acc;
        acc = FILT_KEEP * longint'(prev) + FILT_NEW * (longint'(s) << 8) + 32768;
        return OFF_W'(acc >> 16);
    endfunction

    // Q1.14 amps, sign inverted, rounded half away from zero
    function automatic logic signed [RES_W-1:0] phase_amps(logic [ADC_BITS-1:0] s,
                                                           logic [OFF_W-1:0] off);
        longint d;
        longint g;
        longint den;
        longint mag;
        longint q;
        d   = (longint'(s) << 8) - longint'(off);
        g   = (gain_reg == '0) ? 64'sd1 : longint'(gain_reg);
        den = g << (ADC_BITS - 2);
        mag = (d < 0 ? -d : d) * VREF_AMPS;
        q   = (mag + den / 2) / den;
        if (q > AMPS_CLAMP)
            q = AMPS_CLAMP;
        return clip16(d < 0 ? q : -q);
    endfunction

    task automatic predict_and_queue(input in_item_t item);
        out_item_t res;
        longint    volts;
        res = '0;
        res.phase_status = ST_IDLE;
        if (item.driver_ready && !is_calibrated)
        begin
            if (cal_count < calib_len)
            begin
                offset_a = filter_offset(offset_a, item.phase_a_sample);
                offset_b = filter_offset(offset_b, item.phase_b_sample);
                cal_count = cal_count + 16'd1;
                res.phase_status = ST_CALIBRATING;
            end
            else
            begin
                is_calibrated = 1'b1;
                cal_count = '0;
                res.phase_status = ST_CAL_DONE;
            end
        end
        else if (item.driver_ready)
        begin
            res.phase_status = ST_CONVERTED;
            res.current_a = phase_amps(item.phase_a_sample, offset_a);
            res.current_b = phase_amps(item.phase_b_sample, offset_b);
            res.current_c = clip16(-(longint'(res.current_a) + longint'(res.current_b)));
            volts = (longint'(item.bus_sample) * BUS_SCALE + (64'sd1 << (ADC_BITS + 7)))
                    >> (ADC_BITS + 8);
            if (volts > longint'(volt_limit))
                volts = longint'(volt_limit);
            res.bus_volts = RES_W'(volts);
            res.integrator_limit = RES_W'((volts * LIM_SCALE + 32768) >> 16);
        end
        expected_results.push_back(res);
    endtask

    function automatic void compare_field(string name, logic [15:0] want,
                                          logic [15:0] got, bit is_signed);
        if (got !== want)
        begin
            mismatches++;
            if (is_signed)
                $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            else
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            $error("result transaction with nothing expected, status %0d", got.phase_status);
            return;
        end
        want = expected_results.pop_front();
        status_seen[int'(want.phase_status)]++;
        compare_field("phase_status", 16'(want.phase_status), 16'(got.phase_status), 1'b0);
        compare_field("current_a", want.current_a, got.current_a, 1'b1);
        compare_field("current_b", want.current_b, got.current_b, 1'b1);
        compare_field("current_c", want.current_c, got.current_c, 1'b1);
        compare_field("bus_volts", want.bus_volts, got.bus_volts, 1'b0);
        compare_field("integrator_limit", want.integrator_limit, got.integrator_limit, 1'b0);
    endtask

    function automatic logic [ADC_BITS-1:0] pick_sample(int center);
        int v;
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return ADC_BITS'(ADC_MAX);
        if (r <= 4)
            return ADC_BITS'($urandom);
        // near the zero-current point, where real traffic sits
        v = center + int'($urandom_range(0, 600)) - 300;
        if (v < 0)
            v = 0;
        if (v > ADC_MAX)
            v = ADC_MAX;
        return ADC_BITS'(v);
    endfunction

    function automatic in_item_t make_item(int ready_pct);
        in_item_t it;
        it.driver_ready   = ($urandom_range(0, 99) < ready_pct);
        it.phase_a_sample = pick_sample(int'(offset_a >> 8));
        it.phase_b_sample = pick_sample(int'(offset_b >> 8));
        it.bus_sample     = pick_sample(2048);
        return it;
    endfunction

    function automatic in_item_t sample_set(bit rdy, int a, int b, int bus);
        in_item_t it;
        it.driver_ready   = rdy;
        it.phase_a_sample = ADC_BITS'(a);
        it.phase_b_sample = ADC_BITS'(b);
        it.bus_sample     = ADC_BITS'(bus);
        return it;
    endfunction

    task automatic send_sample(input in_item_t item);
        int gap;
        gap = draw_gap(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid   <= 1'b1;
        samples_ch.payload <= item;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        predict_and_queue(item);
        items_sent++;
    endtask

    // Sender goes quiet until every pending result is back
    task automatic drain_results();
        @(negedge clk);
        samples_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        case (idx)
            REG_CALIB_SAMPLES:  calib_len  = value;
            REG_CURRENT_GAIN:   gain_reg   = value;
            REG_BUS_VOLT_LIMIT: volt_limit = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic test_idle_before_calibration();
        send_sample(sample_set(1'b0, 0, 0, 0));
        send_sample(sample_set(1'b0, ADC_MAX, ADC_MAX, ADC_MAX));
        send_sample(sample_set(1'b0, ADC_MAX, 0, 2048));
        drain_results();
    endtask

    task automatic test_calibration_tracking();
        int n;
        int mode;
        write_reg(REG_CALIB_SAMPLES, 16'hFFFF);
        send_sample(sample_set(1'b1, 0, ADC_MAX, 0));
        send_sample(sample_set(1'b0, ADC_MAX, 0, ADC_MAX));
        send_sample(sample_set(1'b1, ADC_MAX, 0, ADC_MAX));
        send_sample(sample_set(1'b1, 2048, 2048, 2048));
        send_sample(sample_set(1'b0, 0, 0, 0));
        send_sample(sample_set(1'b1, 2000, 2100, 1234));
        for (n = 0; n < 120; n++)
            send_sample(make_item(85));
        drain_results();
        // end calibration by zero count, count below progress, or reaching the count
        mode = $urandom_range(0, 2);
        case (mode)
            0:       write_reg(REG_CALIB_SAMPLES, 16'd0);
            1:       write_reg(REG_CALIB_SAMPLES, 16'd1);
            default: write_reg(REG_CALIB_SAMPLES, CFG_W'(cal_count + $urandom_range(1, 30)));
        endcase
        while (!is_calibrated)
            send_sample(make_item(80));
        drain_results();
    endtask

    task automatic test_conversion_extremes();
        send_sample(sample_set(1'b1, 0, 0, 0));
        send_sample(sample_set(1'b1, ADC_MAX, ADC_MAX, ADC_MAX));
        send_sample(sample_set(1'b1, 0, ADC_MAX, 2048));
        send_sample(sample_set(1'b1, ADC_MAX, 0, ADC_MAX));
        send_sample(sample_set(1'b1, int'(offset_a >> 8), int'(offset_b >> 8), 1000));
        send_sample(sample_set(1'b0, ADC_MAX, ADC_MAX, ADC_MAX));
        drain_results();
    endtask

    task automatic test_output_backpressure();
        int n;
        drain_results();
        hold_results_req = 1'b1;
        for (n = 0; n < 8; n++)
            send_sample(make_item(100));
        drain_results();
    endtask

    task automatic test_gain_and_limit_sweep();
        logic [CFG_W-1:0] gain_set  [6];
        logic [CFG_W-1:0] limit_set [6];
        int k;
        int n;
        gain_set  = '{16'd0, 16'd1, 16'hFFFF, 16'd19661, CFG_W'($urandom), CFG_W'($urandom)};
        limit_set = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd51610, CFG_W'($urandom),
                      CFG_W'($urandom)};
        for (k = 0; k < 6; k++)
        begin
            drain_results();
            write_reg(REG_CURRENT_GAIN, gain_set[k]);
            write_reg(REG_BUS_VOLT_LIMIT, limit_set[k]);
            // count has no effect once calibrated
            if (k == 2)
                write_reg(REG_CALIB_SAMPLES, CFG_W'($urandom));
            for (n = 0; n < 115; n++)
                send_sample(make_item(90));
        end
        drain_results();
    endtask

    initial
    begin : result_sink
        int gap;
        results_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            gap = draw_gap(sink_calm);
            if (hold_results_req)
            begin
                gap = HOLD_CYCLES;
                hold_results_req = 1'b0;
            end
            if (gap > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            results_ch.ready <= 1'b1;
            @(posedge clk);
            while (!results_ch.valid)
                @(posedge clk);
            check_result(results_ch.payload);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (samples_ch.valid && samples_ch.ready)
                       || (results_ch.valid && results_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL adc_offset_calibrate_and_scale");
        $finish;
    end

    initial
    begin : main_sequence
        int waited;
        rst_n              = 1'b0;
        cfg_wen            = 1'b0;
        cfg_index          = REG_CALIB_SAMPLES;
        cfg_data           = '0;
        samples_ch.valid   = 1'b0;
        samples_ch.payload = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_before_calibration();
        test_calibration_tracking();
        test_conversion_extremes();
        test_output_backpressure();
        test_gain_and_limit_sweep();

        for (waited = 0; waited < STALL_LIMIT && expected_results.size() != 0; waited++)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            mismatches++;
            $error("%0d expected results never arrived", expected_results.size());
        end

        $display("Covered %0d sample transactions over %0d register writes:", items_sent,
                 reg_writes);
        $display("  %0d not ready, %0d calibrating, %0d calibration done, %0d converted",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0)
            $display("PASS adc_offset_calibrate_and_scale");
        else
            $display("FAIL adc_offset_calibrate_and_scale");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/aoc_pkg.sv
hw/rtl/aoc_if.sv
hw/rtl/aoc_sequencer.sv
hw/rtl/aoc_datapath.sv
hw/rtl/adc_offset_calibrate_and_scale.sv
dv/tb_top.sv
